/* rtl/core/ptc_pkg.sv */
// Shared verdict codes, class flags and constants of the triple classifier.
package ptc_pkg;

  // Result codes carried in the verdict field
  typedef enum logic [1:0] {
    VERDICT_NONE      = 2'd0,
    VERDICT_TRIPLE    = 2'd1,
    VERDICT_PRIMITIVE = 2'd2,
    VERDICT_RANGE     = 2'd3
  } verdict_t;

  // Front-end classification handed to the back end with the sorted sides
  typedef struct packed {
    logic range_err;
    logic is_triple;
  } ptc_class_t;

  localparam int CLASS_BITS = $bits(ptc_class_t);

  // Response of the gcd unit
  typedef struct packed {
    logic done;
    logic coprime;
  } ptc_gcd_rsp_t;

  // Reset value of the upper limit register, truncated to the value width
  localparam logic [31:0] LIMIT_RESET = 32'd10000;

endpackage

/* rtl/core/ptc_gcd.sv */
// Iterative binary gcd unit that reports whether two nonzero values are coprime.
module ptc_gcd #(
  parameter int VALUE_BITS = 14
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [VALUE_BITS-1:0]    x_in,
  input  logic [VALUE_BITS-1:0]    y_in,
  output ptc_pkg::ptc_gcd_rsp_t    rsp
);
  import ptc_pkg::*;

  typedef enum logic {G_IDLE, G_RUN} gcd_state_t;

  gcd_state_t            state_r;
  logic [VALUE_BITS-1:0] x_r;
  logic [VALUE_BITS-1:0] y_r;
  logic                  twos_r;
  logic                  done_r;
  logic                  coprime_r;

  // One subtract or shift step per cycle until both operands meet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        G_IDLE: begin
          done_r <= 1'b0;
          if (start) begin
            x_r     <= x_in;
            y_r     <= y_in;
            twos_r  <= 1'b0;
            state_r <= G_RUN;
          end
        end
        G_RUN: begin
          if (x_r == y_r) begin
            done_r    <= 1'b1;
            coprime_r <= !twos_r && (x_r == VALUE_BITS'(1));
            state_r   <= G_IDLE;
          end else if (!x_r[0] && !y_r[0]) begin
            // shared factor of two: not coprime
            x_r    <= x_r >> 1;
            y_r    <= y_r >> 1;
            twos_r <= 1'b1;
          end else if (!x_r[0]) begin
            x_r <= x_r >> 1;
          end else if (!y_r[0]) begin
            y_r <= y_r >> 1;
          end else if (x_r > y_r) begin
            x_r <= x_r - y_r;
          end else begin
            y_r <= y_r - x_r;
          end
        end
        default: state_r <= G_IDLE;
      endcase
    end
  end

  assign rsp.done    = done_r;
  assign rsp.coprime = coprime_r;

endmodule

/* rtl/core/ptc_fifo.sv */
// Small register queue between the front end and the back end.
module ptc_fifo #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import ptc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store an entry at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

/* rtl/core/ptc_front.sv */
// Front end: accepts a beat, sorts the sides, checks range and the square sum.
module ptc_front #(
  parameter int VALUE_BITS = 14
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_tvalid,
  output logic                                           in_tready,
  input  logic [((3*VALUE_BITS+7)/8)*8-1:0]              in_tdata,
  input  logic [VALUE_BITS-1:0]                          upper_limit,
  output logic                                           push_valid,
  input  logic                                           push_ready,
  output logic [ptc_pkg::CLASS_BITS+3*VALUE_BITS-1:0]    push_data
);
  import ptc_pkg::*;

  localparam int VB = VALUE_BITS;
  localparam int SQ = 2 * VALUE_BITS;

  typedef enum logic [1:0] {F_IDLE, F_SQR, F_CHK} front_state_t;

  front_state_t  state_r;
  logic [VB-1:0] v0, v1, v2;
  logic [VB-1:0] a1, b1, b2, c2, a3, b3;
  logic          range_ok;
  logic [VB-1:0] a_r, b_r, c_r;
  logic          range_err_r;
  logic [SQ-1:0] aa_r, bb_r, cc_r;
  logic [SQ:0]   sum_sq;
  ptc_class_t    cls;

  // Unpack the three sides
  assign v0 = in_tdata[VB-1:0];
  assign v1 = in_tdata[2*VB-1:VB];
  assign v2 = in_tdata[3*VB-1:2*VB];

  // Three compare-swap stages, largest first
  assign a1 = (v0 < v1) ? v1 : v0;
  assign b1 = (v0 < v1) ? v0 : v1;
  assign b2 = (b1 < v2) ? v2 : b1;
  assign c2 = (b1 < v2) ? b1 : v2;
  assign a3 = (a1 < b2) ? b2 : a1;
  assign b3 = (a1 < b2) ? a1 : b2;

  // Each side must lie in 1 to the upper limit
  assign range_ok = (v0 != '0) && (v1 != '0) && (v2 != '0) &&
                    (v0 <= upper_limit) && (v1 <= upper_limit) && (v2 <= upper_limit);

  // Accept, square, then hand the classified item to the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_tvalid) begin
            a_r         <= a3;
            b_r         <= b3;
            c_r         <= c2;
            range_err_r <= !range_ok;
            state_r     <= F_SQR;
          end
        end
        F_SQR: begin
          aa_r    <= SQ'(a_r) * SQ'(a_r);
          bb_r    <= SQ'(b_r) * SQ'(b_r);
          cc_r    <= SQ'(c_r) * SQ'(c_r);
          state_r <= F_CHK;
        end
        F_CHK: begin
          if (push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign sum_sq        = {1'b0, bb_r} + {1'b0, cc_r};
  assign cls.range_err = range_err_r;
  assign cls.is_triple = ({1'b0, aa_r} == sum_sq);

  assign in_tready  = (state_r == F_IDLE);
  assign push_valid = (state_r == F_CHK);
  assign push_data  = {cls, c_r, b_r, a_r};

endmodule

/* rtl/core/ptc_back.sv */
// Back end: runs the pairwise gcd checks and holds the result beat.
module ptc_back #(
  parameter int VALUE_BITS = 14
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           pop_valid,
  output logic                                           pop_ready,
  input  logic [ptc_pkg::CLASS_BITS+3*VALUE_BITS-1:0]    pop_data,
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  output logic [((2+3*VALUE_BITS+7)/8)*8-1:0]            out_tdata
);
  import ptc_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int OUT_W = ((2 + 3 * VALUE_BITS + 7) / 8) * 8;

  localparam logic [1:0] PAIR_AB = 2'd0;
  localparam logic [1:0] PAIR_BC = 2'd1;
  localparam logic [1:0] PAIR_AC = 2'd2;

  typedef enum logic [1:0] {B_IDLE, B_START, B_WAIT, B_OUT} back_state_t;

  back_state_t   state_r;
  ptc_class_t    cls_r;
  ptc_class_t    pop_cls;
  logic [VB-1:0] a_r, b_r, c_r;
  logic [1:0]    pair_r;
  logic          cop_r;
  logic [VB-1:0] gx, gy;
  ptc_gcd_rsp_t  gcd_rsp;
  verdict_t      verdict;

  assign pop_cls = pop_data[CLASS_BITS+3*VB-1:3*VB];

  // Pick the operand pair for the gcd unit
  always_comb begin
    case (pair_r)
      PAIR_AB: begin gx = a_r; gy = b_r; end
      PAIR_BC: begin gx = b_r; gy = c_r; end
      PAIR_AC: begin gx = a_r; gy = c_r; end
      default: begin gx = a_r; gy = b_r; end
    endcase
  end

  ptc_gcd #(.VALUE_BITS(VALUE_BITS)) u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == B_START),
    .x_in  (gx),
    .y_in  (gy),
    .rsp   (gcd_rsp)
  );

  // Take an entry, check the three pairs if needed, hold the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (pop_valid) begin
            cls_r  <= pop_cls;
            a_r    <= pop_data[VB-1:0];
            b_r    <= pop_data[2*VB-1:VB];
            c_r    <= pop_data[3*VB-1:2*VB];
            cop_r  <= 1'b1;
            pair_r <= PAIR_AB;
            if (pop_cls.is_triple && !pop_cls.range_err) begin
              state_r <= B_START;
            end else begin
              state_r <= B_OUT;
            end
          end
        end
        B_START: state_r <= B_WAIT;
        B_WAIT: begin
          if (gcd_rsp.done) begin
            cop_r <= cop_r && gcd_rsp.coprime;
            if (pair_r == PAIR_AC) begin
              state_r <= B_OUT;
            end else begin
              pair_r  <= pair_r + 2'd1;
              state_r <= B_START;
            end
          end
        end
        B_OUT: begin
          if (out_tready) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // Form the verdict from the class flags and the coprime result
  always_comb begin
    if (cls_r.range_err) begin
      verdict = VERDICT_RANGE;
    end else if (!cls_r.is_triple) begin
      verdict = VERDICT_NONE;
    end else if (cop_r) begin
      verdict = VERDICT_PRIMITIVE;
    end else begin
      verdict = VERDICT_TRIPLE;
    end
  end

  assign pop_ready  = (state_r == B_IDLE);
  assign out_tvalid = (state_r == B_OUT);
  assign out_tdata  = OUT_W'({c_r, b_r, a_r, verdict});

endmodule

/* rtl/core/pythagorean_triple_classifier.sv */
// Top level of the Pythagorean triple classifier.
// Usage:
//   in_*  : one beat carries three candidate sides; the classifier sorts them
//           largest first, checks each against 1..upper_limit, tests whether
//           the largest square equals the sum of the other two squares, and
//           for an in-range triple runs gcd on all three pairs.
//   out_* : one beat per input beat, in order: verdict (0 none, 1 triple,
//           2 primitive, 3 out of range) and the three sorted sides.
//   cfg_* : write cfg_wr_data into upper_limit when cfg_wr_en is high; write
//           only while the block is idle.
// Path: an accepted beat goes through F_SQR and F_CHK in the front end, the
//   queue, and B_OUT in the back end; an in-range triple adds three binary
//   gcd runs, one per pair, before B_OUT.
// Throughput: the front takes a new beat once it has queued the last; the
//   back end is bound by the single shared gcd unit, one subtract or shift
//   per cycle. A two-entry queue lets the front accept while the back works.
// Reset (rst_n low, synchronous): queue empties, both ends go idle,
//   upper_limit returns to 10000.
// Stall: when out_tready is low the result is held; the queue fills and
//   in_tready then drops.
module pythagorean_triple_classifier #(
  parameter int VALUE_BITS = 14
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // first_value, second_value, third_value (low bits first), zero padded
  input  logic [((3*VALUE_BITS+7)/8)*8-1:0]       in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // verdict, largest, middle, smallest (low bits first), zero padded
  output logic [((2+3*VALUE_BITS+7)/8)*8-1:0]     out_tdata,
  input  logic                                    cfg_wr_en,
  input  logic [VALUE_BITS-1:0]                   cfg_wr_data
);
  import ptc_pkg::*;

  localparam int ENTRY_W = CLASS_BITS + 3 * VALUE_BITS;

  logic [VALUE_BITS-1:0] upper_limit_r;
  logic                  push_valid;
  logic                  push_ready;
  logic [ENTRY_W-1:0]    push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [ENTRY_W-1:0]    pop_data;

  // Hold the range limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_limit_r <= LIMIT_RESET[VALUE_BITS-1:0];
    end else if (cfg_wr_en) begin
      upper_limit_r <= cfg_wr_data;
    end
  end

  ptc_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .upper_limit (upper_limit_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  ptc_fifo #(.WIDTH(ENTRY_W), .DEPTH(2)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ptc_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
